FILE: sv/frf_pkg.sv
// Shared types and constants for the frame rotate/flip address generator.
// No dependencies; used by the core and its checker.
`default_nettype none

package frf_pkg;

    localparam int PIXEL_W     = 32;
    localparam int DEST_W      = 24;
    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int XFORM_W     = 3;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 56;
    localparam int DIM_RESET   = 4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_TRANSFORM    = 2'd2
    } cfg_index_t;

    typedef enum logic [XFORM_W-1:0] {
        XF_COPY   = 3'd0,
        XF_ROT90  = 3'd1,
        XF_ROT180 = 3'd2,
        XF_ROT270 = 3'd3,
        XF_HFLIP  = 3'd4,
        XF_VFLIP  = 3'd5
    } xform_t;

endpackage

`default_nettype wire

FILE: sv/frame_rotate_flip_address_gen_core.sv
// Frame rotate/flip address generator: raster counters, operand select, multiply-add.
// Depends on frf_pkg.
`default_nettype none

//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | s_tdata[31:0] pixel_in
//  m_      | out | m_tvalid/tready  | m_tdata[23:0] dest_index, [55:24] pixel_out; m_tlast
//  cfg_wr_ | in  | cfg_wr_en        | cfg_wr_index, cfg_wr_data (13 bits)
//
// One pixel per cycle sustained while the output is not stalled.
// The first register stage steps the column/row counters and selects the
// multiplier operands; the second does the one multiply-add per pixel.
// aresetn (synchronous) restores W = H = min(4096, MAX_DIM), copy, counters zero.
// A stalled output holds its beat while one more pixel waits in the first stage.

module frame_rotate_flip_address_gen_core #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [frf_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] pixel_in
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [frf_pkg::M_TDATA_W-1:0]      m_tdata,   // [23:0] dest_index, [55:24] pixel_out
    output logic                               m_tlast,
    input  wire logic                          cfg_wr_en,
    input  wire logic [frf_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [frf_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int CW = $clog2(MAX_DIM);          // counter / coordinate width
    localparam int DW = $clog2(MAX_DIM + 1);      // dimension width
    localparam int PW = CW + DW;
    localparam int IW = (PW > frf_pkg::DEST_W) ? PW : frf_pkg::DEST_W;
    localparam int RESET_DIM = (frf_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : frf_pkg::DIM_RESET;

    logic [DW-1:0]        width_reg;
    logic [DW-1:0]        height_reg;
    frf_pkg::xform_t      xform_reg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        row_reg;

    logic [DW-1:0]        dim_wr;
    logic [CW-1:0]        w_m1;
    logic [CW-1:0]        h_m1;
    logic                 col_last;
    logic                 row_last;

    logic                 s1_valid_reg;
    logic [CW-1:0]        s1_a_reg, s1_a_next;
    logic [DW-1:0]        s1_b_reg, s1_b_next;
    logic [CW-1:0]        s1_c_reg, s1_c_next;
    logic [frf_pkg::PIXEL_W-1:0] s1_pixel_reg;
    logic                 s1_last_reg;

    logic                 m_valid_reg;
    logic [frf_pkg::DEST_W-1:0]  m_dest_reg;
    logic [frf_pkg::PIXEL_W-1:0] m_pixel_reg;
    logic                 m_last_reg;

    logic                 out_free;
    logic                 s_accept;
    logic                 s1_move;
    logic [IW-1:0]        idx_full;

    // Clamp a written dimension: zero acts as one, oversize as MAX_DIM.
    always_comb begin
        if (cfg_wr_data == '0) begin
            dim_wr = DW'(1);
        end else if (32'(cfg_wr_data) > 32'(MAX_DIM)) begin
            dim_wr = DW'(MAX_DIM);
        end else begin
            dim_wr = DW'(cfg_wr_data);
        end
    end

    assign w_m1     = CW'(width_reg - DW'(1));
    assign h_m1     = CW'(height_reg - DW'(1));
    assign col_last = (col_reg == w_m1);
    assign row_last = (row_reg == h_m1);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign s1_move  = s1_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(RESET_DIM);
            height_reg <= DW'(RESET_DIM);
            xform_reg  <= frf_pkg::XF_COPY;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                frf_pkg::CFG_FRAME_WIDTH: begin
                    width_reg <= dim_wr;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                frf_pkg::CFG_FRAME_HEIGHT: begin
                    height_reg <= dim_wr;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                frf_pkg::CFG_TRANSFORM: begin
                    xform_reg <= frf_pkg::xform_t'(cfg_wr_data[frf_pkg::XFORM_W-1:0]);
                end
                default: begin
                end
            endcase
        end else if (s_accept) begin
            // advance raster position, wrap after the last pixel
            if (col_last) begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + CW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // index = a * b + c
    always_comb begin
        unique case (xform_reg)
            frf_pkg::XF_ROT90: begin
                s1_a_next = col_reg;
                s1_b_next = height_reg;
                s1_c_next = h_m1 - row_reg;
            end
            frf_pkg::XF_ROT180: begin
                s1_a_next = h_m1 - row_reg;
                s1_b_next = width_reg;
                s1_c_next = w_m1 - col_reg;
            end
            frf_pkg::XF_ROT270: begin
                s1_a_next = w_m1 - col_reg;
                s1_b_next = height_reg;
                s1_c_next = row_reg;
            end
            frf_pkg::XF_HFLIP: begin
                s1_a_next = row_reg;
                s1_b_next = width_reg;
                s1_c_next = w_m1 - col_reg;
            end
            frf_pkg::XF_VFLIP: begin
                s1_a_next = h_m1 - row_reg;
                s1_b_next = width_reg;
                s1_c_next = col_reg;
            end
            default: begin
                s1_a_next = row_reg;
                s1_b_next = width_reg;
                s1_c_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_a_reg     <= s1_a_next;
            s1_b_reg     <= s1_b_next;
            s1_c_reg     <= s1_c_next;
            s1_pixel_reg <= s_tdata[frf_pkg::PIXEL_W-1:0];
            s1_last_reg  <= col_last && row_last;
        end
    end

    assign idx_full = IW'(s1_a_reg) * IW'(s1_b_reg) + IW'(s1_c_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_dest_reg  <= idx_full[frf_pkg::DEST_W-1:0];
            m_pixel_reg <= s1_pixel_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_pixel_reg, m_dest_reg};

endmodule

`default_nettype wire

FILE: sv/frf_checker.sv
// Port-level checks for frame_rotate_flip_address_gen_core, attached by bind.
// Depends on frf_pkg.
`default_nettype none

module frf_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [frf_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire logic                              m_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // a fresh output beat comes from an accepted input pixel that passed through the first stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output beat without matching input beat");

    // input only backs up behind a waiting output beat
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output free");

endmodule

bind frame_rotate_flip_address_gen_core frf_checker u_frf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
